FILE: hw/rtl/tagged_serial_frame_receiver_core_assert.svh
// Assertion macros for the serial frame receiver.
// Used by the modules that check their own logic; no other dependencies.
`ifndef TAGGED_SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH
`define TAGGED_SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsfr: assertion failed");
`define TSFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsfr: implication failed");
`else
`define TSFR_ASSERT(lbl, clk, rst_n, prop)
`define TSFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/tsfr_pkg.sv
// Shared types and constants of the serial frame receiver.
// No dependencies; used by tsfr_cfg_regs, tsfr_assembler, tsfr_out_reg and the core.
package tsfr_pkg;

  localparam int unsigned FrameBytes = 13;
  localparam int unsigned StoreBytes = FrameBytes - 1;
  localparam int unsigned CntW       = $clog2(FrameBytes);

  localparam logic [CntW-1:0] LastIdx = CntW'(StoreBytes);

  localparam logic [7:0] HeaderReset = 8'hD8;
  localparam logic [7:0] TailReset   = 8'hEE;

  localparam logic [7:0] TagMode   = 8'hB0;
  localparam logic [7:0] TagAngle  = 8'hB1;
  localparam logic [7:0] TagBranch = 8'hB2;
  localparam logic [7:0] TagCamera = 8'hB3;

  localparam int unsigned PosModeTag   = 1;
  localparam int unsigned PosAngleTag  = 4;
  localparam int unsigned PosBranchTag = 7;
  localparam int unsigned PosCameraTag = 10;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_HEADER_ERR = 2'd1,
    ST_TAIL_ERR   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_TAIL   = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic signed [15:0] move_mode;
    logic signed [15:0] heading_angle;
    logic signed [15:0] branch_word;
    logic [7:0]         camera_error;
  } out_item_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [7:0] wr_data;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
  } cfg_t;

endpackage

FILE: hw/rtl/tsfr_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Payload types come from tsfr_pkg.
interface tsfr_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/tsfr_cfg_regs.sv
// Header and tail byte registers of the serial frame receiver.
// Depends on tsfr_pkg and tsfr_stream_if.
module tsfr_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsfr_stream_if.sink        cfg_i,
  output tsfr_pkg::cfg_t     cfg_o
);

  tsfr_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte <= tsfr_pkg::HeaderReset;
      cfg_q.tail_byte   <= tsfr_pkg::TailReset;
    end else if (cfg_i.valid) begin
      case (tsfr_pkg::reg_idx_e'(cfg_i.payload.reg_index))
        tsfr_pkg::REG_HEADER: cfg_q.header_byte <= cfg_i.payload.wr_data;
        tsfr_pkg::REG_TAIL:   cfg_q.tail_byte   <= cfg_i.payload.wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tsfr_assembler.sv
// Input register, byte count, frame store and held field values.
// Depends on tsfr_pkg, tsfr_stream_if and the assertion header.
`include "tagged_serial_frame_receiver_core_assert.svh"
module tsfr_assembler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsfr_stream_if.sink           rx_i,
  input  tsfr_pkg::cfg_t        cfg_i,
  input  logic                  res_free_i,
  output logic                  res_valid_o,
  output tsfr_pkg::out_item_t   res_o
);

  logic                           in_valid_q;
  logic [7:0]                     in_byte_q;
  logic [tsfr_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [7:0]                     store_q [tsfr_pkg::StoreBytes];
  logic [15:0]                    mode_q, mode_d;
  logic [15:0]                    angle_q, angle_d;
  logic [15:0]                    branch_q, branch_d;
  logic [7:0]                     camera_q, camera_d;
  logic                           is_tail, hdr_miss, good, emits, proc, in_ready;

  assign is_tail  = (cnt_q == tsfr_pkg::LastIdx);
  assign hdr_miss = (cnt_q == '0) && (in_byte_q != cfg_i.header_byte);
  assign good     = is_tail && (in_byte_q == cfg_i.tail_byte);
  assign emits    = in_valid_q && (is_tail || hdr_miss);
  assign proc     = in_valid_q && (!emits || res_free_i);
  assign in_ready = !in_valid_q || proc;

  assign rx_i.ready = in_ready;

  always_comb begin
    mode_d   = mode_q;
    angle_d  = angle_q;
    branch_d = branch_q;
    camera_d = camera_q;
    if (good) begin
      if (store_q[tsfr_pkg::PosModeTag] == tsfr_pkg::TagMode) begin
        mode_d = {store_q[tsfr_pkg::PosModeTag+1], store_q[tsfr_pkg::PosModeTag+2]};
      end
      if (store_q[tsfr_pkg::PosAngleTag] == tsfr_pkg::TagAngle) begin
        angle_d = {store_q[tsfr_pkg::PosAngleTag+1], store_q[tsfr_pkg::PosAngleTag+2]};
      end
      if (store_q[tsfr_pkg::PosBranchTag] == tsfr_pkg::TagBranch) begin
        branch_d = {store_q[tsfr_pkg::PosBranchTag+1], store_q[tsfr_pkg::PosBranchTag+2]};
      end
      if (store_q[tsfr_pkg::PosCameraTag] == tsfr_pkg::TagCamera) begin
        camera_d = store_q[tsfr_pkg::PosCameraTag+1];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (is_tail) begin
      cnt_d = '0;
    end else if (!hdr_miss) begin
      cnt_d = cnt_q + tsfr_pkg::CntW'(1);
    end
  end

  always_comb begin
    res_o.move_mode     = mode_d;
    res_o.heading_angle = angle_d;
    res_o.branch_word   = branch_d;
    res_o.camera_error  = camera_d;
    if (hdr_miss) begin
      res_o.frame_status = tsfr_pkg::ST_HEADER_ERR;
    end else if (good) begin
      res_o.frame_status = tsfr_pkg::ST_GOOD;
    end else begin
      res_o.frame_status = tsfr_pkg::ST_TAIL_ERR;
    end
  end

  assign res_valid_o = emits && res_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
      mode_q     <= '0;
      angle_q    <= '0;
      branch_q   <= '0;
      camera_q   <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (proc) begin
        cnt_q    <= cnt_d;
        mode_q   <= mode_d;
        angle_q  <= angle_d;
        branch_q <= branch_d;
        camera_q <= camera_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_i.valid) begin
      in_byte_q <= rx_i.payload.rx_byte;
    end
    if (proc && !is_tail && !hdr_miss) begin
      store_q[cnt_q] <= in_byte_q;
    end
  end

  `TSFR_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= tsfr_pkg::LastIdx)
  `TSFR_ASSERT(a_close_clears, clk_i, rst_ni, (proc && is_tail) |=> (cnt_q == '0))
  `TSFR_ASSERT(a_hdr_miss_stays, clk_i, rst_ni, (proc && hdr_miss) |=> (cnt_q == '0))
  `TSFR_ASSERT_IMP(a_mode_on_good, clk_i, rst_ni, mode_q != $past(mode_q), $past(proc && good))
  `TSFR_ASSERT_IMP(a_cam_on_good, clk_i, rst_ni, camera_q != $past(camera_q), $past(proc && good))

endmodule

FILE: hw/rtl/tsfr_out_reg.sv
// Result register between the frame assembler and the result channel.
// Depends on tsfr_pkg and tsfr_stream_if.
module tsfr_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  input  tsfr_pkg::out_item_t   res_i,
  output logic                  res_free_o,
  tsfr_stream_if.source         res_o
);

  logic                 valid_q;
  tsfr_pkg::out_item_t  item_q;

  assign res_free_o    = !valid_q || res_o.ready;
  assign res_o.valid   = valid_q;
  assign res_o.payload = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free_o && res_valid_i) begin
      item_q <= res_i;
    end
  end

endmodule

FILE: hw/rtl/tagged_serial_frame_receiver_core.sv
// Serial frame receiver: 13-byte frames, header/tail check, tagged field hold.
// Path: a result passes the input register and then the result register from rx_i to res_o.
// Throughput: one byte per cycle while res_o keeps up; set by the result register.
// Reset: count, held values and valid flags clear; header 0xD8, tail 0xEE.
// Depends on tsfr_pkg, tsfr_stream_if, tsfr_cfg_regs, tsfr_assembler, tsfr_out_reg.
module tagged_serial_frame_receiver_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  tsfr_stream_if.sink    rx_i,
  tsfr_stream_if.source  res_o,
  tsfr_stream_if.sink    cfg_i
);

  tsfr_pkg::cfg_t       cfg;
  tsfr_pkg::out_item_t  res_item;
  logic                 res_valid;
  logic                 res_free;

  tsfr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tsfr_assembler u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cfg_i       (cfg),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  tsfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_item),
    .res_free_o  (res_free),
    .res_o       (res_o)
  );

endmodule
